@@ design/fbph_pkg.sv @@
// Shared types and constants for the float bit pattern histogram.
// Stand-alone package; every design file imports it.
package fbph_pkg;

    localparam int TOTAL_BITS = 48;
    localparam int BIN_OUT_BITS = 32;
    localparam int FUNC_BITS = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int BASE_BITS = 12;
    localparam int READ_BITS = 12;

    // Function codes on the input channel
    localparam logic [FUNC_BITS-1:0] FUNC_COUNT = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE = 2'd1;

    // Operation handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam int OP_BITS = $bits(op_t);

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } back_state_t;

    // Status from the back end to the front end
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

@@ design/fbph_front.sv @@
// Front end: configuration registers, input acceptance and sample classification.
// Depends on fbph_pkg.
module fbph_front #(
    parameter int BUCKET_BITS = 12,
    parameter int SUB_BITS    = 12,
    parameter int STORE_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fbph_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fbph_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fbph_pkg::FUNC_BITS-1:0]       func,
    input  logic [63:0]                          sample,
    input  logic [fbph_pkg::READ_BITS-1:0]       bin,
    input  fbph_pkg::back_stat_t                 back_stat,
    input  logic                                 q_space,
    output logic                                 q_push,
    output logic [fbph_pkg::OP_BITS+STORE_BITS-1:0] q_data
);
    import fbph_pkg::*;

    localparam int CMP_BITS = (BUCKET_BITS > BASE_BITS) ? BUCKET_BITS : BASE_BITS;

    logic                 mode_reg;
    logic [BASE_BITS-1:0] base_reg;
    logic [10:0]          exp_f;
    logic                 kept;
    logic                 hit;
    logic [BUCKET_BITS-1:0] top_f;
    logic [SUB_BITS-1:0]  sub_f;
    op_t                  op;
    logic [STORE_BITS-1:0] idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE: mode_reg <= cfg_data[0];
                CFG_BASE: base_reg <= cfg_data[BASE_BITS-1:0];
                default:  ;
            endcase
        end
    end

    // Keep zeros and normals; drop subnormals, infinities and NaNs
    always_comb
    begin
        exp_f = sample[62:52];
        top_f = sample[63 -: BUCKET_BITS];
        sub_f = sample[63-BUCKET_BITS -: SUB_BITS];
        if (exp_f == 11'd0)
            kept = (sample[51:0] == 52'd0);
        else
            kept = (exp_f != 11'h7FF);
        hit = kept && (!mode_reg || (CMP_BITS'(top_f) == CMP_BITS'(base_reg)));
    end

    always_comb
    begin
        op  = OP_NOP;
        idx = '0;
        unique case (func)
            FUNC_COUNT:
            begin
                op  = hit ? OP_COUNT : OP_NOP;
                idx = mode_reg ? STORE_BITS'(sub_f) : STORE_BITS'(top_f);
            end
            FUNC_READ:
            begin
                op  = OP_READ;
                idx = STORE_BITS'(bin);
            end
            FUNC_CLEAR: op = OP_CLEAR;
            default:    op = OP_NOP;
        endcase
    end

    assign in_ready = q_space && !back_stat.clearing;
    assign q_push   = in_valid && in_ready;
    assign q_data   = {op, idx};

endmodule

@@ design/fbph_queue.sv @@
// Two-entry queue decoupling the front end from the back end.
// Depends on fbph_pkg for the house import only.
module fbph_queue #(
    parameter int WIDTH = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             space,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import fbph_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign space     = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/fbph_back.sv @@
// Back end: bin store, read-modify-write sequencer, clearing sweep, total and result register.
// Depends on fbph_pkg.
module fbph_back #(
    parameter int STORE_BITS = 12,
    parameter int COUNT_BITS = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_valid,
    input  logic [fbph_pkg::OP_BITS+STORE_BITS-1:0]  q_data,
    output logic                                     q_pop,
    output fbph_pkg::back_stat_t                     back_stat,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [fbph_pkg::BIN_OUT_BITS-1:0]        bin_count,
    output logic [fbph_pkg::TOTAL_BITS-1:0]          accepted_total,
    output logic                                     counted
);
    import fbph_pkg::*;

    localparam int DEPTH = 1 << STORE_BITS;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;

    back_state_t           state_reg;
    back_state_t           state_next;
    op_t                   op_reg;
    logic [STORE_BITS-1:0] idx_reg;
    logic [STORE_BITS-1:0] sweep_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic                  out_valid_reg;
    logic [BIN_OUT_BITS-1:0] bin_count_reg;
    logic [TOTAL_BITS-1:0] total_out_reg;
    logic                  counted_reg;

    op_t                   q_op;
    logic [STORE_BITS-1:0] q_idx;
    logic                  slot_free;
    logic                  finish;
    logic                  mem_we;
    logic [STORE_BITS-1:0] mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic [STORE_BITS-1:0] rd_addr;
    logic [COUNT_BITS-1:0] inc_count;
    logic [BIN_OUT_BITS-1:0] rd_sat;

    assign q_op  = op_t'(q_data[OP_BITS+STORE_BITS-1:STORE_BITS]);
    assign q_idx = q_data[STORE_BITS-1:0];

    // Report wide counts clipped to the result field
    generate
        if (COUNT_BITS > BIN_OUT_BITS)
        begin : g_wide
            assign rd_sat = (|rd_data_reg[COUNT_BITS-1:BIN_OUT_BITS]) ? '1
                          : rd_data_reg[BIN_OUT_BITS-1:0];
        end
        else
        begin : g_narrow
            assign rd_sat = BIN_OUT_BITS'(rd_data_reg);
        end
    endgenerate

    assign inc_count = (rd_data_reg == '1) ? rd_data_reg
                     : rd_data_reg + COUNT_BITS'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (sweep_reg == STORE_BITS'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (q_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (slot_free)
                    state_next = (op_reg == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        slot_free          = !out_valid_reg || out_ready;
        q_pop              = (state_reg == ST_IDLE) && q_valid;
        finish             = (state_reg == ST_EXEC) && slot_free;
        back_stat.clearing = (state_reg == ST_CLEAR);
        rd_addr            = (state_reg == ST_IDLE) ? q_idx : idx_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = sweep_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = finish && (op_reg == OP_COUNT);
            mem_wa = idx_reg;
            mem_wd = inc_count;
        end
        total_next = total_reg;
        if (finish && op_reg == OP_COUNT && total_reg != '1)
            total_next = total_reg + TOTAL_BITS'(1);
        else if (finish && op_reg == OP_CLEAR)
            total_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg  <= q_op;
            idx_reg <= q_idx;
        end
        if (finish)
        begin
            bin_count_reg <= (op_reg == OP_READ) ? rd_sat : '0;
            total_out_reg <= total_next;
            counted_reg   <= (op_reg == OP_COUNT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                sweep_reg <= sweep_reg + STORE_BITS'(1);
            total_reg <= total_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bin_count      = bin_count_reg;
    assign accepted_total = total_out_reg;
    assign counted        = counted_reg;

`ifndef SYNTH
    a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (total_reg == '0))
        else $error("total not zero during clearing sweep");

    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && op_reg == OP_CLEAR) |=> (state_reg == ST_CLEAR && sweep_reg == '0))
        else $error("clearing sweep did not start at entry zero");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && op_reg == OP_COUNT && total_reg != '1)
        |=> (total_reg == $past(total_reg) + TOTAL_BITS'(1)))
        else $error("total did not advance on a counted sample");
`endif

endmodule

@@ design/float_bit_pattern_histogram_top.sv @@
// Top level of the float bit pattern histogram.
// Depends on fbph_pkg, fbph_front, fbph_queue and fbph_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, sample and bin. func
//   counts a double bit pattern, reads one bin or clears all bins and the
//   total. Each transfer yields exactly one result on the output channel
//   (out_valid/out_ready): bin_count, accepted_total and counted.
//   Configuration: cfg_we with cfg_index/cfg_data writes mode or base_bucket;
//   write only while the block is idle.
//   Path: the input transfer is written into the two-entry queue, popped by
//   the back end in ST_IDLE, carried out in ST_EXEC and then registered.
//   Items: the back end takes no new item until it is through with the last;
//   each bin is read in ST_IDLE and written in ST_EXEC, with no overlap between items.
//   A clear op sweeps all 2^max(BUCKET_BITS,SUB_BITS) entries of the store
//   (4096 at default), one entry a cycle; in_ready is low while it runs.
//   Reset: the same clearing sweep runs after reset before any item is taken;
//   configuration writes are taken throughout.
//   Receiver stall: the result register holds; the back end waits and the
//   two-entry queue fills, after which in_ready drops.
module float_bit_pattern_histogram_top #(
    parameter int BUCKET_BITS = 12,
    parameter int SUB_BITS    = 12,
    parameter int COUNT_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fbph_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fbph_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fbph_pkg::FUNC_BITS-1:0]      func,
    input  logic [63:0]                         sample,
    input  logic [fbph_pkg::READ_BITS-1:0]      bin,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fbph_pkg::BIN_OUT_BITS-1:0]   bin_count,
    output logic [fbph_pkg::TOTAL_BITS-1:0]     accepted_total,
    output logic                                counted
);
    import fbph_pkg::*;

    // Store is as deep as the wider of the two binning schemes needs
    localparam int STORE_BITS = (BUCKET_BITS > SUB_BITS) ? BUCKET_BITS : SUB_BITS;
    localparam int Q_WIDTH    = OP_BITS + STORE_BITS;

    back_stat_t         back_stat;
    logic               q_space;
    logic               q_push;
    logic [Q_WIDTH-1:0] q_push_data;
    logic               q_pop;
    logic               q_valid;
    logic [Q_WIDTH-1:0] q_pop_data;

    // Front end: hold configuration, classify each transfer into an op
    fbph_front #(
        .BUCKET_BITS (BUCKET_BITS),
        .SUB_BITS    (SUB_BITS),
        .STORE_BITS  (STORE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .sample    (sample),
        .bin       (bin),
        .back_stat (back_stat),
        .q_space   (q_space),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    // Decouple: let either side stall on its own
    fbph_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .space     (q_space),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_pop_data)
    );

    // Back end: carry out each op against the bin store
    fbph_back #(
        .STORE_BITS (STORE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .back_stat      (back_stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_count      (bin_count),
        .accepted_total (accepted_total),
        .counted        (counted)
    );

endmodule

@@ sim/tb_float_bit_pattern_histogram_top.sv @@
// Self-checking testbench for float_bit_pattern_histogram_top.
// Depends on fbph_pkg and the histogram RTL; predicts every result in SystemVerilog
// and checks each output transfer against the oldest prediction.
module tb_float_bit_pattern_histogram_top;
    import fbph_pkg::*;

    // Unused function code: the block must leave all state alone
    localparam logic [FUNC_BITS-1:0] FUNC_SPARE = 2'd3;
    localparam int STORE_DEPTH = 4096;
    // Quiet cycles allowed: reset sweep or clear sweep plus the long hold, several times
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [BIN_OUT_BITS-1:0] bin_count;
        logic [TOTAL_BITS-1:0]   accepted_total;
        logic                    counted;
    } hist_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [FUNC_BITS-1:0]     in_func = '0;
    logic [63:0]              in_sample = '0;
    logic [READ_BITS-1:0]     in_bin = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [BIN_OUT_BITS-1:0]  bin_count;
    logic [TOTAL_BITS-1:0]    accepted_total;
    logic                     counted;

    // Predictor state: its own copy of the store, the total and the registers
    logic [31:0]         bin_tally [STORE_DEPTH];
    logic [TOTAL_BITS-1:0] sample_total = '0;
    logic                cur_mode = 1'b0;
    logic [BASE_BITS-1:0] cur_base = '0;

    // Bins recently counted into, so that random reads mostly hit live entries
    logic [11:0] recent_bins [8];
    int          recent_wr = 0;
    logic [11:0] hot_tops [4];

    hist_result_t pending_results [$];
    hist_result_t got_r, exp_r;

    bit idle_en  = 1'b1;
    bit hold_req = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_counted = 0;
    int n_clears = 0;

    float_bit_pattern_histogram_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (in_func),
        .sample         (in_sample),
        .bin            (in_bin),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_count      (bin_count),
        .accepted_total (accepted_total),
        .counted        (counted)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        foreach (recent_bins[i]) recent_bins[i] = '0;
        foreach (hot_tops[i]) hot_tops[i] = '0;
    end

    // Work out the result of one accepted transfer and advance the predictor state.
    function automatic hist_result_t predict_result(input logic [FUNC_BITS-1:0] f,
                                                    input logic [63:0] s,
                                                    input logic [READ_BITS-1:0] b);
        hist_result_t r;
        logic [10:0]  expo;
        logic [11:0]  idx;
        logic         kept;
        r = '0;
        case (f)
            FUNC_COUNT:
            begin
                // Keep zero and normals; drop subnormals, infinities and NaNs
                expo = s[62:52];
                kept = (expo == 11'h000) ? (s[51:0] == 52'd0) : (expo != 11'h7FF);
                idx  = (cur_mode == 1'b0) ? s[63:52] : s[51:40];
                if (kept && (cur_mode == 1'b0 || s[63:52] == cur_base))
                begin
                    // Saturate both the bin and the total
                    if (bin_tally[idx] != '1)
                        bin_tally[idx] = bin_tally[idx] + 1'b1;
                    if (sample_total != '1)
                        sample_total = sample_total + 1'b1;
                    r.counted = 1'b1;
                    recent_bins[recent_wr] = idx;
                    recent_wr = (recent_wr + 1) % 8;
                    n_counted++;
                end
            end
            FUNC_READ:
                r.bin_count = bin_tally[b];
            FUNC_CLEAR:
            begin
                foreach (bin_tally[i]) bin_tally[i] = '0;
                sample_total = '0;
                n_clears++;
            end
            default: ;
        endcase
        r.accepted_total = sample_total;
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record its prediction.
    task automatic send_item(input logic [FUNC_BITS-1:0] f, input logic [63:0] s,
                             input logic [READ_BITS-1:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_func   <= f;
        in_sample <= s;
        in_bin    <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_result(f, s, b));
        n_sent++;
    endtask

    // Drop valid and wait until every result is back and the store is not sweeping.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || !in_ready) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; called while idle, and once during the reset sweep.
    task automatic set_config(input logic mode_v, input logic [BASE_BITS-1:0] base_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= {11'($urandom), mode_v};
        @(posedge clk);
        cfg_index <= CFG_BASE;
        cfg_data  <= base_v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_mode = mode_v;
        cur_base = base_v;
    endtask

    task automatic pick_hot_tops();
        for (int i = 0; i < 3; i++)
            hot_tops[i] = {1'($urandom), 11'($urandom_range(1, 2046))};
        hot_tops[3] = 12'($urandom);
    endtask

    // One random item: mostly samples aimed at a few live buckets, with reads of
    // recently hit bins, the occasional unused code and a rare clear.
    task automatic send_random_item();
        logic [63:0]          rnd;
        logic [63:0]          s;
        logic [11:0]          hint;
        logic [READ_BITS-1:0] b;
        logic [FUNC_BITS-1:0] f;
        int                   sel;
        int                   cls;
        rnd  = {$urandom, $urandom};
        b    = 12'($urandom);
        sel  = $urandom_range(0, 999);
        cls  = $urandom_range(0, 99);
        hint = (cur_mode && $urandom_range(0, 4) != 0) ? cur_base
                                                       : hot_tops[$urandom_range(0, 3)];
        if (cls < 55)
            s = {hint, rnd[51:0]};
        else if (cls < 62)
            s = {rnd[63], 63'd0};
        else if (cls < 70)
            s = {rnd[63], 11'h000, rnd[51:1], 1'b1};
        else if (cls < 76)
            s = {rnd[63], 11'h7FF, 52'd0};
        else if (cls < 83)
            s = {rnd[63], 11'h7FF, rnd[51:1], 1'b1};
        else
            s = rnd;
        if (sel < 700)
            f = FUNC_COUNT;
        else if (sel < 930)
        begin
            f = FUNC_READ;
            if ($urandom_range(0, 9) < 7)
                b = recent_bins[$urandom_range(0, 7)];
        end
        else if (sel < 995)
            f = FUNC_SPARE;
        else
            f = FUNC_CLEAR;
        send_item(f, s, b);
    endtask

    // Directed mode 0: signed zeros, subnormal, normal, infinity and NaN edges,
    // reads at both ends of the index range and the unused code.
    task automatic test_mode0_directed();
        set_config(1'b0, 12'h000);
        send_item(FUNC_COUNT, 64'h0000_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'h8000_0000_0000_0000, 12'hFFF);
        send_item(FUNC_COUNT, 64'h0000_0000_0000_0001, 12'h000);
        send_item(FUNC_COUNT, 64'h000F_FFFF_FFFF_FFFF, 12'h000);
        send_item(FUNC_COUNT, 64'h0010_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'h7FEF_FFFF_FFFF_FFFF, 12'h000);
        send_item(FUNC_COUNT, 64'h7FF0_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'hFFF0_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'h7FF8_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 12'h000);
        send_item(FUNC_COUNT, 64'h3FF0_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'hFFEF_FFFF_FFFF_FFFF, 12'h000);
        send_item(FUNC_READ, 64'hFFFF_FFFF_FFFF_FFFF, 12'h000);
        send_item(FUNC_READ, 64'h0, 12'h800);
        send_item(FUNC_READ, 64'h0, 12'hFFF);
        send_item(FUNC_READ, 64'h0, 12'h7FE);
        send_item(FUNC_SPARE, 64'h3FF0_0000_0000_0000, 12'h000);
    endtask

    // Directed mode 1 without a clear, so counts mix with the mode 0 ones; then
    // base bucket at its top (never kept) and bottom (only +0 matches).
    task automatic test_mode1_directed();
        wait_idle();
        set_config(1'b1, 12'h3FF);
        send_item(FUNC_COUNT, 64'h3FF0_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'h3FFF_F000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'h4000_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'hBFF0_0000_0000_0000, 12'h000);
        send_item(FUNC_READ, 64'h0, 12'h000);
        send_item(FUNC_READ, 64'h0, 12'hFFF);
        wait_idle();
        set_config(1'b1, 12'hFFF);
        send_item(FUNC_COUNT, 64'hFFF8_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'hFFF0_0000_0000_0000, 12'h000);
        wait_idle();
        set_config(1'b1, 12'h000);
        send_item(FUNC_COUNT, 64'h0000_0000_0000_0000, 12'h000);
        send_item(FUNC_COUNT, 64'h0000_0000_0000_0001, 12'h000);
        send_item(FUNC_COUNT, 64'h0010_0000_0000_0000, 12'h000);
    endtask

    // Clear shows a zero total at once; two clears with a read between, then a fresh count.
    task automatic test_clear_directed();
        send_item(FUNC_CLEAR, 64'h0, 12'h000);
        send_item(FUNC_READ, 64'h0, 12'h000);
        send_item(FUNC_CLEAR, 64'h0, 12'h000);
        send_item(FUNC_COUNT, 64'h0000_0000_0000_0000, 12'h000);
    endtask

    // Random stream in mode 0, with the odd pause until everything has come back.
    task automatic test_random_mode0();
        wait_idle();
        set_config(1'b0, 12'($urandom));
        pick_hot_tops();
        for (int i = 0; i < 450; i++)
        begin
            if ($urandom_range(0, 149) == 0)
                wait_idle();
            send_random_item();
        end
    endtask

    // Random stream in mode 1 around a base bucket of ordinary normals.
    task automatic test_random_mode1();
        wait_idle();
        set_config(1'b1, {1'($urandom), 11'($urandom_range(1, 2046))});
        pick_hot_tops();
        for (int i = 0; i < 400; i++)
        begin
            if ($urandom_range(0, 149) == 0)
                wait_idle();
            send_random_item();
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering,
    // so the queue fills and in_ready drops.
    task automatic test_receiver_hold();
        idle_en  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_random_item();
        idle_en = 1'b1;
    endtask

    // Last part: no idling on either side, mode flipped without a clear.
    task automatic test_no_idle_tail();
        wait_idle();
        idle_en = 1'b0;
        set_config(~cur_mode, {1'($urandom), 11'($urandom_range(1, 2046))});
        pick_hot_tops();
        hot_tops[0] = cur_base;
        for (int i = 0; i < 450; i++)
            send_random_item();
    endtask

    // Receiver: random stall bursts, plus the long hold when asked for.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 5) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Checker and watchdog: compare each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            n_results++;
            got_r = '{bin_count, accepted_total, counted};
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: bin_count %0d total %0d counted %0b",
                             bin_count, accepted_total, counted);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got_r.bin_count !== exp_r.bin_count
                    || got_r.accepted_total !== exp_r.accepted_total
                    || got_r.counted !== exp_r.counted)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch at result %0d: exp bin_count %0d total %0d",
                                  " counted %0b, got bin_count %0d total %0d counted %0b"},
                                 n_results, exp_r.bin_count, exp_r.accepted_total,
                                 exp_r.counted, got_r.bin_count, got_r.accepted_total,
                                 got_r.counted);
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // Hold reset at the start, then release it once for the whole run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_mode0_directed();
        test_mode1_directed();
        test_clear_directed();
        test_random_mode0();
        test_random_mode1();
        test_receiver_hold();
        test_no_idle_tail();
        wait_idle();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            n_errors++;
        $display("Sent %0d transfers, checked %0d results, %0d samples counted, %0d clears.",
                 n_sent, n_results, n_counted, n_clears);
        $display("Both modes, base bucket extremes, long receiver hold and drain pauses run.");
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
